>>> hdl/vgmcs_pkg.sv
// Shared types and constants for the sound-log command stream converter.
package vgmcs_pkg;

    // Command opcodes of the data section
    localparam logic [7:0] OP_REG_WRITE = 8'h5A;
    localparam logic [7:0] OP_WAIT_WORD = 8'h61;
    localparam logic [7:0] OP_WAIT_60HZ = 8'h62;
    localparam logic [7:0] OP_WAIT_50HZ = 8'h63;
    localparam logic [7:0] OP_END       = 8'h66;
    localparam logic [3:0] OP_WAIT_SHORT_HI = 4'h7;  // 0x70..0x7F

    localparam logic [15:0] WAIT_60HZ_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_50HZ_SAMPLES = 16'd882;

    // 44100 Hz samples per 980 Hz tick, and floor(2^22 / 45) for the
    // reciprocal divide
    localparam logic [5:0]  SAMPLES_PER_TICK = 6'd45;
    localparam logic [16:0] TICK_RECIP       = 17'd93206;
    localparam int          TICK_RECIP_SHIFT = 22;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_WAIT  = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OPCODE   = 2'd1,
        ERR_TRUNC    = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        PHASE_OPCODE = 3'b001,
        PHASE_PARAM1 = 3'b010,
        PHASE_PARAM2 = 3'b100
    } phase_t;

    typedef struct packed {
        logic        emit;
        kind_t       kind;
        logic [7:0]  reg_address;
        logic [7:0]  reg_value;
        logic [10:0] wait_ticks;
        err_t        error_code;
    } result_t;

    typedef struct packed {
        logic        overflow;
        logic [30:0] total_next;
        logic [5:0]  rem_next;
        logic [10:0] ticks;
    } wait_res_t;

endpackage

>>> hdl/vgm_command_stream_converter.sv
// Top level of the sound-log command stream converter: beat registers and parser.
//
// Converts the data section of a sound-log stream, one byte per input beat,
// into register-write, wait, end-of-data and error results. Waits accumulate
// into a 31-bit sample total; time is reported in 980 Hz ticks with the
// sub-tick remainder (samples modulo 45) carried exactly, and a wait result
// appears only when at least one whole tick was gained. Assert s_pass_start
// on the first byte of every pass: parsing restarts while timing carries on,
// which is how looping is done. After end of data, an error, or the byte
// flagged s_section_last, bytes are consumed silently until the next pass
// start. Each byte produces zero or one result. Throughput is one byte per
// clock while m_ready is high: a beat lands in the input register, is
// decoded by a single pass of logic (the divide by 45 is a reciprocal
// multiply with one correction step) and the result lands in the output
// register.
// A result waiting on m_ready holds the input stage; with m_ready high the
// block takes a byte every cycle. Unused result fields read zero.
module vgm_command_stream_converter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_pass_start,
    input  logic        s_section_last,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_reg_address,
    output logic [7:0]  m_reg_value,
    output logic [10:0] m_wait_ticks,
    output logic [1:0]  m_error_code
);

    // input beat register
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_start_reg;
    logic       in_last_reg;

    // result register
    vgmcs_pkg::result_t out_reg;
    logic               out_valid_reg;

    vgmcs_pkg::result_t result;
    logic               advance;

    // decode the held beat when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    vgmcs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .data_byte   (in_data_reg),
        .pass_start  (in_start_reg),
        .section_last(in_last_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg  <= s_data_byte;
            in_start_reg <= s_pass_start;
            in_last_reg  <= s_section_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result.emit) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = 2'(out_reg.kind);
    assign m_reg_address = out_reg.reg_address;
    assign m_reg_value   = out_reg.reg_value;
    assign m_wait_ticks  = out_reg.wait_ticks;
    assign m_error_code  = 2'(out_reg.error_code);

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("pending result overwritten");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held beat dropped");

    a_out_is_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.emit) |=> (m_valid && out_reg.emit))
        else $error("emitted result not presented");
`endif

endmodule

>>> hdl/vgmcs_tick_conv.sv
// Sample total update and exact 44100 Hz to 980 Hz tick conversion.
module vgmcs_tick_conv (
    input  logic [15:0]          wait_samples,
    input  logic [30:0]          total,
    input  logic [5:0]           remainder,
    output vgmcs_pkg::wait_res_t res
);

    logic [31:0] sum_total;
    logic [16:0] samples;
    logic [33:0] prod;
    logic [10:0] q0;
    logic [16:0] r0_wide;
    logic [6:0]  r0;

    assign sum_total = {1'b0, total} + {16'b0, wait_samples};
    assign samples   = {11'b0, remainder} + {1'b0, wait_samples};

    // floor reciprocal: q0 is the quotient or one below it
    assign prod    = {17'b0, samples} * {17'b0, vgmcs_pkg::TICK_RECIP};
    assign q0      = prod[vgmcs_pkg::TICK_RECIP_SHIFT +: 11];
    assign r0_wide = samples - ({6'b0, q0} * {11'b0, vgmcs_pkg::SAMPLES_PER_TICK});
    assign r0      = r0_wide[6:0];

    always_comb begin
        res.overflow   = sum_total[31];
        res.total_next = sum_total[30:0];
        if (r0 >= {1'b0, vgmcs_pkg::SAMPLES_PER_TICK}) begin
            res.ticks    = q0 + 11'd1;
            res.rem_next = 6'(r0 - {1'b0, vgmcs_pkg::SAMPLES_PER_TICK});
        end else begin
            res.ticks    = q0;
            res.rem_next = r0[5:0];
        end
    end

endmodule

>>> hdl/vgmcs_parser.sv
// Command decoder with parse and timing state; one byte per step.
module vgmcs_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  logic [7:0]         data_byte,
    input  logic               pass_start,
    input  logic               section_last,
    output vgmcs_pkg::result_t result
);

    vgmcs_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic        pending_write_reg, pending_write_next;
    logic [7:0]  first_param_reg, first_param_next;
    logic [5:0]  rem_reg, rem_next;
    logic [30:0] total_reg, total_next;
    logic        halted_reg, halted_next;

    logic        do_wait;
    logic [15:0] wait_samples;
    vgmcs_pkg::wait_res_t wres;

    vgmcs_tick_conv u_tick_conv (
        .wait_samples(wait_samples),
        .total       (total_reg),
        .remainder   (rem_reg),
        .res         (wres)
    );

    always_comb begin
        phase_eff          = pass_start ? vgmcs_pkg::PHASE_OPCODE : phase_reg;
        phase_next         = phase_eff;
        halted_next        = pass_start ? 1'b0 : halted_reg;
        pending_write_next = pending_write_reg;
        first_param_next   = first_param_reg;
        rem_next           = rem_reg;
        total_next         = total_reg;
        do_wait            = 1'b0;
        wait_samples       = '0;
        result             = '0;
        result.kind        = vgmcs_pkg::KIND_WRITE;
        result.error_code  = vgmcs_pkg::ERR_NONE;

        if (!halted_next) begin
            case (phase_eff)
                vgmcs_pkg::PHASE_PARAM1: begin
                    first_param_next = data_byte;
                    if (section_last) begin
                        result.emit       = 1'b1;
                        result.kind       = vgmcs_pkg::KIND_ERROR;
                        result.error_code = vgmcs_pkg::ERR_TRUNC;
                        phase_next        = vgmcs_pkg::PHASE_OPCODE;
                        halted_next       = 1'b1;
                    end else begin
                        phase_next = vgmcs_pkg::PHASE_PARAM2;
                    end
                end
                vgmcs_pkg::PHASE_PARAM2: begin
                    phase_next = vgmcs_pkg::PHASE_OPCODE;
                    if (pending_write_reg) begin
                        result.emit        = 1'b1;
                        result.kind        = vgmcs_pkg::KIND_WRITE;
                        result.reg_address = first_param_reg;
                        result.reg_value   = data_byte;
                    end else begin
                        do_wait      = 1'b1;
                        wait_samples = {data_byte, first_param_reg};
                    end
                end
                default: begin
                    // opcode phase
                    phase_next = vgmcs_pkg::PHASE_OPCODE;
                    if (data_byte == vgmcs_pkg::OP_END) begin
                        result.emit = 1'b1;
                        result.kind = vgmcs_pkg::KIND_END;
                        halted_next = 1'b1;
                    end else if (data_byte[7:4] == vgmcs_pkg::OP_WAIT_SHORT_HI) begin
                        do_wait      = 1'b1;
                        wait_samples = {12'b0, data_byte[3:0]} + 16'd1;
                    end else if (data_byte == vgmcs_pkg::OP_WAIT_50HZ) begin
                        do_wait      = 1'b1;
                        wait_samples = vgmcs_pkg::WAIT_50HZ_SAMPLES;
                    end else if (data_byte == vgmcs_pkg::OP_WAIT_60HZ) begin
                        do_wait      = 1'b1;
                        wait_samples = vgmcs_pkg::WAIT_60HZ_SAMPLES;
                    end else if (data_byte == vgmcs_pkg::OP_WAIT_WORD ||
                                 data_byte == vgmcs_pkg::OP_REG_WRITE) begin
                        if (section_last) begin
                            result.emit       = 1'b1;
                            result.kind       = vgmcs_pkg::KIND_ERROR;
                            result.error_code = vgmcs_pkg::ERR_TRUNC;
                            halted_next       = 1'b1;
                        end else begin
                            pending_write_next = (data_byte == vgmcs_pkg::OP_REG_WRITE);
                            phase_next         = vgmcs_pkg::PHASE_PARAM1;
                        end
                    end else begin
                        result.emit       = 1'b1;
                        result.kind       = vgmcs_pkg::KIND_ERROR;
                        result.error_code = vgmcs_pkg::ERR_OPCODE;
                        halted_next       = 1'b1;
                    end
                end
            endcase

            // zero-length word wait changes nothing
            if (do_wait && wait_samples != 16'd0) begin
                if (wres.overflow) begin
                    result.emit       = 1'b1;
                    result.kind       = vgmcs_pkg::KIND_ERROR;
                    result.error_code = vgmcs_pkg::ERR_OVERFLOW;
                    phase_next        = vgmcs_pkg::PHASE_OPCODE;
                    halted_next       = 1'b1;
                end else begin
                    total_next = wres.total_next;
                    rem_next   = wres.rem_next;
                    if (wres.ticks != 11'd0) begin
                        result.emit       = 1'b1;
                        result.kind       = vgmcs_pkg::KIND_WAIT;
                        result.wait_ticks = wres.ticks;
                    end
                end
            end

            if (section_last) begin
                halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= vgmcs_pkg::PHASE_OPCODE;
            pending_write_reg <= 1'b0;
            first_param_reg   <= '0;
            rem_reg           <= '0;
            total_reg         <= '0;
            halted_reg        <= 1'b0;
        end else if (step) begin
            phase_reg         <= phase_next;
            pending_write_reg <= pending_write_next;
            first_param_reg   <= first_param_next;
            rem_reg           <= rem_next;
            total_reg         <= total_next;
            halted_reg        <= halted_next;
        end
    end

`ifndef SYNTHESIS
    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < vgmcs_pkg::SAMPLES_PER_TICK)
        else $error("tick remainder out of range");

    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.emit && result.kind == vgmcs_pkg::KIND_WAIT) |-> result.wait_ticks != 11'd0)
        else $error("wait result with zero ticks");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && !pass_start) |-> !result.emit)
        else $error("result while halted");

    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.emit && result.kind == vgmcs_pkg::KIND_ERROR) |=> halted_reg)
        else $error("error did not halt parser");

    a_overflow_keeps_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && result.emit && result.error_code == vgmcs_pkg::ERR_OVERFLOW)
        |=> total_reg == $past(total_reg))
        else $error("overflow changed sample total");
`endif

endmodule

>>> test/vgmcs_checker.sv
// Checker: watches both channels, predicts converter results and compares them.
`timescale 1ns / 1ps

module vgmcs_checker
    import vgmcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_pass_start,
    input  logic        s_section_last,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_kind,
    input  logic [7:0]  m_reg_address,
    input  logic [7:0]  m_reg_value,
    input  logic [10:0] m_wait_ticks,
    input  logic [1:0]  m_error_code,

    output int          mismatch_count,
    output int          results_due
);

    localparam logic [30:0] SAMPLE_SUM_MAX = 31'h7FFF_FFFF;

    typedef struct {
        kind_t       kind;
        logic [7:0]  addr;
        logic [7:0]  value;
        logic [10:0] ticks;
        err_t        err;
    } cmd_result_t;

    cmd_result_t awaited_results[$];

    phase_t      cmd_phase;
    logic        write_pending;
    logic [7:0]  held_byte;
    logic [5:0]  sub_tick;
    logic [30:0] samples_elapsed;
    logic        silenced;
    int          mismatches;

    task automatic post_result(input kind_t k, input logic [7:0] a, input logic [7:0] v,
                               input logic [10:0] t, input err_t e);
        cmd_result_t r;
        r.kind  = k;
        r.addr  = a;
        r.value = v;
        r.ticks = t;
        r.err   = e;
        awaited_results.push_back(r);
    endtask

    task automatic abort_stream(input err_t e);
        silenced  = 1'b1;
        cmd_phase = PHASE_OPCODE;
        post_result(KIND_ERROR, 8'd0, 8'd0, 11'd0, e);
    endtask

    // Add samples to the running total; remainder below one tick is carried
    task automatic accrue_wait(input logic [15:0] w);
        logic [16:0] s;
        logic [10:0] ticks;
        if (w == 16'd0)
            return;
        if (samples_elapsed > SAMPLE_SUM_MAX - w) begin
            abort_stream(ERR_OVERFLOW);
            return;
        end
        samples_elapsed = samples_elapsed + w;
        s               = sub_tick + w;
        ticks           = 11'(s / SAMPLES_PER_TICK);
        sub_tick        = 6'(s % SAMPLES_PER_TICK);
        if (ticks != 11'd0)
            post_result(KIND_WAIT, 8'd0, 8'd0, ticks, ERR_NONE);
    endtask

    task automatic convert_byte(input logic [7:0] b, input logic start, input logic last);
        if (start) begin
            cmd_phase = PHASE_OPCODE;
            silenced  = 1'b0;
        end
        if (silenced)
            return;
        case (cmd_phase)
            PHASE_PARAM1: begin
                held_byte = b;
                if (last) begin
                    abort_stream(ERR_TRUNC);
                    return;
                end
                cmd_phase = PHASE_PARAM2;
            end
            PHASE_PARAM2: begin
                cmd_phase = PHASE_OPCODE;
                if (write_pending)
                    post_result(KIND_WRITE, held_byte, b, 11'd0, ERR_NONE);
                else
                    accrue_wait({b, held_byte});
            end
            default: begin
                cmd_phase = PHASE_OPCODE;
                if (b == OP_END) begin
                    silenced = 1'b1;
                    post_result(KIND_END, 8'd0, 8'd0, 11'd0, ERR_NONE);
                    return;
                end else if (b[7:4] == OP_WAIT_SHORT_HI) begin
                    accrue_wait({12'd0, b[3:0]} + 16'd1);
                end else if (b == OP_WAIT_50HZ) begin
                    accrue_wait(WAIT_50HZ_SAMPLES);
                end else if (b == OP_WAIT_60HZ) begin
                    accrue_wait(WAIT_60HZ_SAMPLES);
                end else if (b == OP_WAIT_WORD || b == OP_REG_WRITE) begin
                    if (last) begin
                        abort_stream(ERR_TRUNC);
                        return;
                    end
                    write_pending = (b == OP_REG_WRITE);
                    cmd_phase     = PHASE_PARAM1;
                end else begin
                    abort_stream(ERR_OPCODE);
                    return;
                end
            end
        endcase
        if (last)
            silenced = 1'b1;
    endtask

    always @(posedge aclk) begin
        cmd_result_t exp;
        if (!aresetn) begin
            awaited_results.delete();
            cmd_phase       = PHASE_OPCODE;
            write_pending   = 1'b0;
            held_byte       = 8'd0;
            sub_tick        = 6'd0;
            samples_elapsed = 31'd0;
            silenced        = 1'b0;
            mismatches      = 0;
        end else begin
            // a result passes the input and output registers after its byte, so compare first
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result k%0d a%02h v%02h t%0d e%0d",
                             $time, m_kind, m_reg_address, m_reg_value,
                             m_wait_ticks, m_error_code);
                    mismatches++;
                end else begin
                    exp = awaited_results.pop_front();
                    if (m_kind !== exp.kind || m_reg_address !== exp.addr ||
                        m_reg_value !== exp.value || m_wait_ticks !== exp.ticks ||
                        m_error_code !== exp.err) begin
                        $display("%0t: expected k%0d a%02h v%02h t%0d e%0d, got k%0d a%02h v%02h t%0d e%0d",
                                 $time, exp.kind, exp.addr, exp.value, exp.ticks,
                                 exp.err, m_kind, m_reg_address, m_reg_value,
                                 m_wait_ticks, m_error_code);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                convert_byte(s_data_byte, s_pass_start, s_section_last);
        end
        mismatch_count <= mismatches;
        results_due    <= awaited_results.size();
    end

endmodule

>>> test/tb_top.sv
// Testbench top: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import vgmcs_pkg::*;

    localparam int RANDOM_BEATS = 1500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 10;         // extra wait once no result is awaited

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_pass_start;
    logic        s_section_last;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [7:0]  m_reg_address;
    logic [7:0]  m_reg_value;
    logic [10:0] m_wait_ticks;
    logic [1:0]  m_error_code;

    int          mismatch_count;
    int          results_due;

    int          beats;        // counts bytes sent while live is set
    bit          idle_on;      // random gaps and stalls enabled
    bit          restart_due;  // stream likely halted; favor a pass start
    bit          live;         // current command is not expected to be ignored

    vgm_command_stream_converter u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_pass_start   (s_pass_start),
        .s_section_last (s_section_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_reg_address  (m_reg_address),
        .m_reg_value    (m_reg_value),
        .m_wait_ticks   (m_wait_ticks),
        .m_error_code   (m_error_code)
    );

    vgmcs_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_pass_start   (s_pass_start),
        .s_section_last (s_section_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_reg_address  (m_reg_address),
        .m_reg_value    (m_reg_value),
        .m_wait_ticks   (m_wait_ticks),
        .m_error_code   (m_error_code),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    // Result side back-pressure: random stall bursts while idling is on.
    // Once idling is switched off the current burst ends and m_ready stays high.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // One input beat: optional gap with valid low, then hold valid until taken.
    // s_ready is read right after the edge, i.e. the value the edge sampled.
    task automatic send_byte(input logic [7:0] b, input logic st, input logic lst);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_pass_start   <= st;
        s_section_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (live)
            beats++;
    endtask

    // Two-parameter command; a section_last may land on any of its three bytes
    // (on the opcode or first parameter that is a truncation).
    task automatic send_with_params(input logic [7:0] op, input logic [15:0] prm,
                                    input logic st, input logic lst);
        int cut;
        cut = lst ? $urandom_range(0, 2) : 3;
        send_byte(op, st, cut == 0);
        send_byte(prm[7:0], 1'b0, cut == 1);
        send_byte(prm[15:8], 1'b0, cut == 2);
    endtask

    // Mostly well-formed commands with random content, some stray bytes,
    // occasional pass starts mid-stream and early section ends.
    task automatic send_command();
        int          pick;
        int          span;
        logic        st;
        logic        lst;
        logic [3:0]  nib;
        logic [15:0] count;
        pick = $urandom_range(0, 99);
        st   = ($urandom_range(0, 11) == 0) ||
               (restart_due && $urandom_range(0, 7) != 0);
        lst  = ($urandom_range(0, 39) == 0);
        live = st || !restart_due;
        if (st)
            restart_due = 1'b0;
        if (pick < 20) begin
            nib = 4'($urandom_range(0, 15));
            send_byte({OP_WAIT_SHORT_HI, nib}, st, lst);
        end else if (pick < 28) begin
            send_byte(OP_WAIT_50HZ, st, lst);
        end else if (pick < 36) begin
            send_byte(OP_WAIT_60HZ, st, lst);
        end else if (pick < 56) begin
            span = $urandom_range(0, 7);
            if (span == 0)
                count = 16'd0;
            else if (span < 4)
                count = 16'($urandom_range(1, 90));
            else
                count = 16'($urandom_range(0, 65535));
            send_with_params(OP_WAIT_WORD, count, st, lst);
        end else if (pick < 86) begin
            send_with_params(OP_REG_WRITE, 16'($urandom_range(0, 65535)), st, lst);
        end else if (pick < 90) begin
            send_byte(OP_END, st, lst);
            restart_due = 1'b1;
        end else begin
            send_byte(8'($urandom_range(0, 255)), st, lst);
            restart_due = 1'b1;
        end
        if (lst)
            restart_due = 1'b1;
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_data_byte    <= 8'd0;
        s_pass_start   <= 1'b0;
        s_section_last <= 1'b0;
        beats       = 0;
        idle_on     = 1'b0;
        restart_due = 1'b0;
        live        = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every opcode, field extremes, zero wait, truncations,
        // bad opcodes, halting and restart from every halt but overflow
        send_byte(8'h70, 1'b1, 1'b0);            // 1 sample, no tick yet
        send_byte(8'h7F, 1'b0, 1'b0);            // 16 samples
        send_byte(OP_WAIT_50HZ, 1'b0, 1'b0);     // remainder ends at 44
        send_with_params(OP_WAIT_WORD, 16'hFFFF, 1'b0, 1'b0);  // largest tick count
        send_byte(OP_WAIT_60HZ, 1'b0, 1'b0);
        send_with_params(OP_REG_WRITE, 16'hFF00, 1'b0, 1'b0);
        send_with_params(OP_REG_WRITE, 16'h00FF, 1'b0, 1'b0);
        send_with_params(OP_WAIT_WORD, 16'h0000, 1'b0, 1'b0);  // zero wait, no result
        send_byte(OP_WAIT_WORD, 1'b0, 1'b1);     // truncated at the opcode
        send_byte(OP_REG_WRITE, 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b1);            // truncated at the first parameter
        send_byte(8'h00, 1'b1, 1'b0);            // unsupported opcode
        send_byte(8'h70, 1'b0, 1'b0);            // ignored while halted
        send_byte(8'hFF, 1'b1, 1'b0);            // unsupported opcode
        send_byte(8'h7A, 1'b1, 1'b1);            // wait on the last byte, then halted
        send_byte(8'h70, 1'b0, 1'b0);            // ignored
        send_byte(OP_END, 1'b1, 1'b0);
        send_byte(8'h71, 1'b0, 1'b0);            // ignored after end of data
        send_byte(OP_REG_WRITE, 1'b1, 1'b0);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(OP_WAIT_50HZ, 1'b1, 1'b0);     // pass start cuts the write short

        // Random commands, with stretches where neither side idles
        beats = 0;
        while (beats < RANDOM_BEATS) begin
            idle_on = (beats % 400) >= 80;
            send_command();
        end

        // Last part, no idling: restart and run a few back-to-back commands
        idle_on = 1'b0;
        live    = 1'b1;
        send_with_params(OP_WAIT_WORD, 16'hFFFF, 1'b1, 1'b0);
        send_with_params(OP_REG_WRITE, 16'h4433, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(OP_END, 1'b0, 1'b0);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> vgm_command_stream_converter.f
hdl/vgmcs_pkg.sv
hdl/vgmcs_tick_conv.sv
hdl/vgmcs_parser.sv
hdl/vgm_command_stream_converter.sv
test/vgmcs_checker.sv
test/tb_top.sv
